// ----- design/register_byte_taint_tracker_core_defines.svh -----
// ----------------------------------------------------------------------------
// register_byte_taint_tracker_core_defines.svh
// Assertion helper macros for the taint tracker core RTL
// ----------------------------------------------------------------------------
`ifndef REGISTER_BYTE_TAINT_TRACKER_CORE_DEFINES_SVH
`define REGISTER_BYTE_TAINT_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RBTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbtt same-cycle check failed");

// next-cycle implication, checked out of reset
`define RBTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbtt next-cycle check failed");

`endif

// ----- design/rbtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rbtt_pkg
// Shared types and constants of the register byte taint tracker
// ----------------------------------------------------------------------------
package rbtt_pkg;

  // fixed field widths
  localparam int unsigned LANES_MAX   = 8;
  localparam int unsigned REG_IDX_W   = 5;
  localparam int unsigned IP_W        = 64;

  // default sizing
  localparam int unsigned DEF_REGISTER_COUNT     = 16;
  localparam int unsigned DEF_BYTES_PER_REGISTER = 8;

  // lanes cleared by a self-zeroing sub/xor
  localparam logic [LANES_MAX-1:0] ZERO_LANES = 8'h0F;

  // operation codes
  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_QUERY = 3'd2,
    OP_MOVE  = 3'd3,
    OP_ARITH = 3'd4,
    OP_LOAD  = 3'd5
  } rbtt_op_e;

  // one decoded transaction
  typedef struct packed {
    rbtt_op_e               op;
    logic [REG_IDX_W-1:0]   dst;
    logic [REG_IDX_W-1:0]   src;
    logic [REG_IDX_W-1:0]   src2;
    logic                   dst_ok;
    logic                   src_ok;
    logic                   src2_ok;
    logic                   same_regs;
    logic [LANES_MAX-1:0]   dst_sel;
    logic [LANES_MAX-1:0]   src_sel;
    logic [IP_W-1:0]        ip;
    logic                   mem;
    logic                   zeroing;
  } rbtt_item_t;

  // operands read from the shadow register file
  typedef struct packed {
    logic [LANES_MAX-1:0]   lanes_d;
    logic [LANES_MAX-1:0]   lanes_s;
    logic [LANES_MAX-1:0]   lanes_s2;
    logic [IP_W-1:0]        origin_d;
  } rbtt_rd_t;

  // write request into the shadow register file
  typedef struct packed {
    logic                   we;
    logic                   org_we;
    logic [REG_IDX_W-1:0]   addr;
    logic [LANES_MAX-1:0]   lanes;
    logic [IP_W-1:0]        origin;
  } rbtt_wr_t;

  // result fields
  typedef struct packed {
    logic                   tainted;
    logic [IP_W-1:0]        last_ip;
    logic                   ignored;
  } rbtt_res_t;

endpackage

// ----- design/rbtt_regfile.sv -----
// ----------------------------------------------------------------------------
// rbtt_regfile
// Shadow taint storage: per-lane taint bits and origin address per register,
// registered reads with write forwarding
// ----------------------------------------------------------------------------
module rbtt_regfile #(
  parameter int unsigned REGISTER_COUNT     = rbtt_pkg::DEF_REGISTER_COUNT,
  parameter int unsigned BYTES_PER_REGISTER = rbtt_pkg::DEF_BYTES_PER_REGISTER
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  rbtt_pkg::rbtt_item_t rd_item_i,
  input  rbtt_pkg::rbtt_wr_t  wr_i,
  output rbtt_pkg::rbtt_rd_t  rd_o
);
  import rbtt_pkg::*;

  localparam int unsigned IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  // two copies of the lane store give three read ports
  logic [BYTES_PER_REGISTER-1:0] lanes_a_mem [REGISTER_COUNT];
  logic [BYTES_PER_REGISTER-1:0] lanes_b_mem [REGISTER_COUNT];
  logic [IP_W-1:0]               origin_mem  [REGISTER_COUNT];

  logic [REGISTER_COUNT-1:0] lane_vld_q;
  logic [REGISTER_COUNT-1:0] org_vld_q;

  logic [IDX_W-1:0] w_idx;
  logic [IDX_W-1:0] d_idx;
  logic [IDX_W-1:0] s_idx;
  logic [IDX_W-1:0] s2_idx;
  logic             fwd_d;
  logic             fwd_s;
  logic             fwd_s2;
  logic             fwd_org;
  rbtt_rd_t         rd_q;

  assign w_idx  = wr_i.addr[IDX_W-1:0];
  assign d_idx  = rd_item_i.dst[IDX_W-1:0];
  assign s_idx  = rd_item_i.src[IDX_W-1:0];
  assign s2_idx = rd_item_i.src2[IDX_W-1:0];

  // a write in this cycle supersedes the stored entry
  assign fwd_d   = wr_i.we && (wr_i.addr == rd_item_i.dst);
  assign fwd_s   = wr_i.we && (wr_i.addr == rd_item_i.src);
  assign fwd_s2  = wr_i.we && (wr_i.addr == rd_item_i.src2);
  assign fwd_org = wr_i.org_we && (wr_i.addr == rd_item_i.dst);

  // entry valid bits, an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= '0;
      org_vld_q  <= '0;
    end else begin
      if (wr_i.we) begin
        lane_vld_q[w_idx] <= 1'b1;
      end
      if (wr_i.org_we) begin
        org_vld_q[w_idx] <= 1'b1;
      end
    end
  end

  // storage write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      lanes_a_mem[w_idx] <= wr_i.lanes[BYTES_PER_REGISTER-1:0];
      lanes_b_mem[w_idx] <= wr_i.lanes[BYTES_PER_REGISTER-1:0];
    end
    if (wr_i.org_we) begin
      origin_mem[w_idx] <= wr_i.origin;
    end
  end

  // registered read ports, loaded when a transaction enters
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (!rd_item_i.dst_ok) begin
        rd_q.lanes_d <= '0;
      end else if (fwd_d) begin
        rd_q.lanes_d <= wr_i.lanes;
      end else if (!lane_vld_q[d_idx]) begin
        rd_q.lanes_d <= '0;
      end else begin
        rd_q.lanes_d <= LANES_MAX'(lanes_a_mem[d_idx]);
      end

      if (!rd_item_i.src_ok) begin
        rd_q.lanes_s <= '0;
      end else if (fwd_s) begin
        rd_q.lanes_s <= wr_i.lanes;
      end else if (!lane_vld_q[s_idx]) begin
        rd_q.lanes_s <= '0;
      end else begin
        rd_q.lanes_s <= LANES_MAX'(lanes_a_mem[s_idx]);
      end

      if (!rd_item_i.src2_ok) begin
        rd_q.lanes_s2 <= '0;
      end else if (fwd_s2) begin
        rd_q.lanes_s2 <= wr_i.lanes;
      end else if (!lane_vld_q[s2_idx]) begin
        rd_q.lanes_s2 <= '0;
      end else begin
        rd_q.lanes_s2 <= LANES_MAX'(lanes_b_mem[s2_idx]);
      end

      if (!rd_item_i.dst_ok) begin
        rd_q.origin_d <= '0;
      end else if (fwd_org) begin
        rd_q.origin_d <= wr_i.origin;
      end else if (!org_vld_q[d_idx]) begin
        rd_q.origin_d <= '0;
      end else begin
        rd_q.origin_d <= origin_mem[d_idx];
      end
    end
  end

  assign rd_o = rd_q;

endmodule

// ----- design/rbtt_alu.sv -----
// ----------------------------------------------------------------------------
// rbtt_alu
// Taint propagation logic: computes the register write and the result fields
// of one transaction from its operands
// ----------------------------------------------------------------------------
module rbtt_alu #(
  parameter int unsigned BYTES_PER_REGISTER = rbtt_pkg::DEF_BYTES_PER_REGISTER
) (
  input  rbtt_pkg::rbtt_item_t item_i,
  input  rbtt_pkg::rbtt_rd_t   rd_i,
  output rbtt_pkg::rbtt_wr_t   wr_o,
  output rbtt_pkg::rbtt_res_t  res_o
);
  import rbtt_pkg::*;

  localparam int unsigned BPR = BYTES_PER_REGISTER;

  logic [BPR-1:0] dm;
  logic [BPR-1:0] sm;
  logic [BPR-1:0] zl;
  logic [BPR-1:0] cur_d;
  logic [BPR-1:0] cur_s;
  logic [BPR-1:0] cur_s2;
  logic [BPR-1:0] new_lanes;
  logic           defined;
  logic           uses_src;
  logic           ignored;
  logic           act;
  logic           we;
  logic           org_we;
  logic           tainted;

  // lanes beyond the register width drop out here
  assign dm     = item_i.dst_sel[BPR-1:0];
  assign sm     = item_i.src_sel[BPR-1:0];
  assign zl     = ZERO_LANES[BPR-1:0];
  assign cur_d  = rd_i.lanes_d[BPR-1:0];
  assign cur_s  = rd_i.lanes_s[BPR-1:0];
  assign cur_s2 = rd_i.lanes_s2[BPR-1:0];

  // range checks
  always_comb begin
    defined  = 1'b0;
    uses_src = 1'b0;
    unique case (item_i.op)
      OP_SET, OP_CLEAR, OP_QUERY, OP_LOAD: defined = 1'b1;
      OP_MOVE, OP_ARITH: begin
        defined  = 1'b1;
        uses_src = 1'b1;
      end
      default: defined = 1'b0;
    endcase
  end

  assign ignored = defined && (!item_i.dst_ok || (uses_src && !item_i.src_ok));
  assign act     = defined && !ignored;

  // lane update per operation
  always_comb begin
    new_lanes = cur_d;
    we        = 1'b0;
    org_we    = 1'b0;
    tainted   = 1'b0;
    unique case (item_i.op)
      OP_SET: begin
        new_lanes = cur_d | dm;
        we        = 1'b1;
        org_we    = 1'b1;
      end
      OP_CLEAR: begin
        new_lanes = cur_d & ~dm;
        we        = 1'b1;
      end
      OP_QUERY: begin
        tainted = |(cur_d & dm);
      end
      OP_MOVE: begin
        new_lanes = (cur_d & ~dm) | (cur_s & sm & dm);
        we        = 1'b1;
      end
      OP_ARITH: begin
        we = 1'b1;
        priority if (item_i.zeroing && item_i.same_regs) begin
          new_lanes = cur_d & ~zl;
        end else if (item_i.src2_ok) begin
          new_lanes = cur_s | cur_s2;
        end else begin
          new_lanes = cur_s;
        end
      end
      OP_LOAD: begin
        new_lanes = item_i.mem ? (cur_d | dm) : (cur_d & ~dm);
        we        = 1'b1;
      end
      default: begin
        new_lanes = cur_d;
      end
    endcase
  end

  assign wr_o.we     = act && we;
  assign wr_o.org_we = act && org_we;
  assign wr_o.addr   = item_i.dst;
  assign wr_o.lanes  = LANES_MAX'(new_lanes);
  assign wr_o.origin = item_i.ip;

  assign res_o.tainted = act && tainted;
  assign res_o.last_ip = (act && (item_i.op == OP_QUERY)) ? rd_i.origin_d : '0;
  assign res_o.ignored = ignored;

endmodule

// ----- design/register_byte_taint_tracker_core.sv -----
// ----------------------------------------------------------------------------
// register_byte_taint_tracker_core
// Per-byte register taint shadow for dynamic information flow tracking
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one taint operation per
//   transaction: set, clear, query, masked move, arithmetic merge or memory
//   load. Output channel (out_valid_o / out_stall_i) returns exactly one
//   result transaction per input: query flag, recorded origin address and
//   the out-of-range flag.
//   Pipeline: operands are read into the operand stage when a transaction is
//   accepted, and the result register loads when that stage advances to the
//   output.
//   Throughput: one transaction per cycle unless the receiver stalls; the register
//   file reads operands on entry and forwards the write of the transaction ahead,
//   so back-to-back dependent operations need no bubble.
//   Reset: all taint bits and origin addresses read as zero, both stages
//   empty.
//   Stall: a stalled result holds its register; the operand stage holds its
//   transaction and in_stall_o rises only when both stages are full and the
//   receiver stalls.
// ----------------------------------------------------------------------------
`include "register_byte_taint_tracker_core_defines.svh"

module register_byte_taint_tracker_core #(
  parameter int unsigned REGISTER_COUNT     = rbtt_pkg::DEF_REGISTER_COUNT,
  parameter int unsigned BYTES_PER_REGISTER = rbtt_pkg::DEF_BYTES_PER_REGISTER
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [4:0]  dst_reg_i,
  input  logic [4:0]  src_reg_i,
  input  logic [4:0]  second_src_reg_i,
  input  logic [7:0]  dst_mask_i,
  input  logic [7:0]  src_mask_i,
  input  logic [63:0] source_ip_i,
  input  logic        mem_tainted_i,
  input  logic        zeroing_op_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tainted_o,
  output logic [63:0] last_taint_ip_o,
  output logic        ignored_o
);
  import rbtt_pkg::*;

  localparam int unsigned CMP_W = REG_IDX_W + 1;

  rbtt_item_t item_d;
  rbtt_item_t item_q;
  logic       s1_valid_q;
  logic       out_valid_q;
  logic       tainted_q;
  logic [IP_W-1:0] last_ip_q;
  logic       ignored_q;
  logic       accept;
  logic       advance;
  rbtt_rd_t   rd;
  rbtt_wr_t   alu_wr;
  rbtt_wr_t   rf_wr;
  rbtt_res_t  alu_res;

  // decode the incoming transaction
  always_comb begin
    item_d.op        = rbtt_op_e'(operation_i);
    item_d.dst       = dst_reg_i;
    item_d.src       = src_reg_i;
    item_d.src2      = second_src_reg_i;
    item_d.dst_ok    = {1'b0, dst_reg_i} < CMP_W'(REGISTER_COUNT);
    item_d.src_ok    = {1'b0, src_reg_i} < CMP_W'(REGISTER_COUNT);
    item_d.src2_ok   = {1'b0, second_src_reg_i} < CMP_W'(REGISTER_COUNT);
    item_d.same_regs = (dst_reg_i == src_reg_i) && (src_reg_i == second_src_reg_i);
    item_d.dst_sel   = dst_mask_i;
    item_d.src_sel   = src_mask_i;
    item_d.ip        = source_ip_i;
    item_d.mem       = mem_tainted_i;
    item_d.zeroing   = zeroing_op_i;
  end

  // handshake
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // operand stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // operand stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  // shadow register file
  always_comb begin
    rf_wr        = alu_wr;
    rf_wr.we     = advance && alu_wr.we;
    rf_wr.org_we = advance && alu_wr.org_we;
  end

  rbtt_regfile #(
    .REGISTER_COUNT    (REGISTER_COUNT),
    .BYTES_PER_REGISTER(BYTES_PER_REGISTER)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_item_i(item_d),
    .wr_i     (rf_wr),
    .rd_o     (rd)
  );

  // taint propagation
  rbtt_alu #(
    .BYTES_PER_REGISTER(BYTES_PER_REGISTER)
  ) u_alu (
    .item_i(item_q),
    .rd_i  (rd),
    .wr_o  (alu_wr),
    .res_o (alu_res)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      tainted_q <= alu_res.tainted;
      last_ip_q <= alu_res.last_ip;
      ignored_q <= alu_res.ignored;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tainted_o       = tainted_q;
  assign last_taint_ip_o = last_ip_q;
  assign ignored_o       = ignored_q;

  // checks
  `RBTT_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, in_stall_o,
                   s1_valid_q && out_valid_q && out_stall_i)
  `RBTT_ASSERT_NXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `RBTT_ASSERT_IMP(a_query_no_write, clk_i, rst_ni, s1_valid_q && (item_q.op == OP_QUERY),
                   !alu_wr.we && !alu_wr.org_we)
  `RBTT_ASSERT_NXT(a_ignored_clean, clk_i, rst_ni, advance && alu_res.ignored,
                   !tainted_o && (last_taint_ip_o == '0))

endmodule

// ----- tb/tb_register_byte_taint_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_byte_taint_tracker_core
// Self-checking bench for the per-byte register taint shadow
// ----------------------------------------------------------------------------
// A short list of directed transactions covers reset state, field extremes,
// out-of-range indices, undefined operation codes, absent second sources and
// self-zeroing arithmetic. A long random run follows. A local shadow of the
// lane taint bits and origin addresses predicts each unscripted result; it
// is compared field by field in order. Both channels idle at random, and
// the result side holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module tb_register_byte_taint_tracker_core;
  import rbtt_pkg::*;

  localparam int unsigned NREG       = DEF_REGISTER_COUNT;
  localparam int unsigned NLANE      = DEF_BYTES_PER_REGISTER;
  localparam logic [7:0]  LANE_BITS  = 8'hFF >> (8 - NLANE);
  localparam logic [2:0]  OP_UNDEF_A = 3'd6;
  localparam logic [2:0]  OP_UNDEF_B = 3'd7;
  localparam int unsigned RAND_ITEMS = 1225;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // one taint operation as driven on the input channel
  typedef struct {
    logic [2:0]  op;
    logic [4:0]  dst;
    logic [4:0]  src;
    logic [4:0]  src2;
    logic [7:0]  dmask;
    logic [7:0]  smask;
    logic [63:0] ip;
    logic        mem;
    logic        zero;
  } taint_op_t;

  // directed row: operation plus an optional hand-written result
  typedef struct {
    taint_op_t item;
    bit        typed;
    rbtt_res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [4:0]  dst_reg_i = '0;
  logic [4:0]  src_reg_i = '0;
  logic [4:0]  second_src_reg_i = '0;
  logic [7:0]  dst_mask_i = '0;
  logic [7:0]  src_mask_i = '0;
  logic [63:0] source_ip_i = '0;
  logic        mem_tainted_i = 1'b0;
  logic        zeroing_op_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        tainted_o;
  logic [63:0] last_taint_ip_o;
  logic        ignored_o;

  // shadow state and pending results
  logic [7:0]  shadow_lanes [NREG];
  logic [63:0] shadow_origin [NREG];
  rbtt_res_t   pending_results [$];
  dir_row_t    dir_rows [$];

  int unsigned mismatches = 0;
  bit          stim_done = 1'b0;
  bit          rx_hold = 1'b0;
  int unsigned tx_mode = 0;
  int unsigned tx_mode_left = 0;

  register_byte_taint_tracker_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .dst_reg_i       (dst_reg_i),
    .src_reg_i       (src_reg_i),
    .second_src_reg_i(second_src_reg_i),
    .dst_mask_i      (dst_mask_i),
    .src_mask_i      (src_mask_i),
    .source_ip_i     (source_ip_i),
    .mem_tainted_i   (mem_tainted_i),
    .zeroing_op_i    (zeroing_op_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tainted_o       (tainted_o),
    .last_taint_ip_o (last_taint_ip_o),
    .ignored_o       (ignored_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // apply one operation to the shadow and return its result
  function automatic rbtt_res_t track_taint(input taint_op_t it);
    rbtt_res_t  r;
    logic [7:0] dm;
    logic [7:0] sm;
    logic [7:0] taken;
    r = '0;
    dm = it.dmask & LANE_BITS;
    sm = it.smask & LANE_BITS;
    if (it.op > OP_LOAD) return r;
    if (it.dst >= NREG || ((it.op == OP_MOVE || it.op == OP_ARITH) && it.src >= NREG)) begin
      r.ignored = 1'b1;
      return r;
    end
    case (it.op)
      OP_SET: begin
        shadow_lanes[it.dst] = shadow_lanes[it.dst] | dm;
        shadow_origin[it.dst] = it.ip;
      end
      OP_CLEAR: shadow_lanes[it.dst] = shadow_lanes[it.dst] & ~dm;
      OP_QUERY: begin
        r.tainted = |(shadow_lanes[it.dst] & dm);
        r.last_ip = shadow_origin[it.dst];
      end
      OP_MOVE: begin
        taken = shadow_lanes[it.src] & sm & dm;
        shadow_lanes[it.dst] = (shadow_lanes[it.dst] & ~dm) | taken;
      end
      OP_ARITH: begin
        // sub/xor of a register with itself wipes the low four lanes
        if (it.zero && it.dst == it.src && it.src == it.src2)
          shadow_lanes[it.dst] = shadow_lanes[it.dst] & ~(ZERO_LANES & LANE_BITS);
        else if (it.src2 < NREG)
          shadow_lanes[it.dst] = (shadow_lanes[it.src] | shadow_lanes[it.src2]) & LANE_BITS;
        else
          shadow_lanes[it.dst] = shadow_lanes[it.src] & LANE_BITS;
      end
      default: begin
        if (it.mem) shadow_lanes[it.dst] = shadow_lanes[it.dst] | dm;
        else shadow_lanes[it.dst] = shadow_lanes[it.dst] & ~dm;
      end
    endcase
    return r;
  endfunction

  function automatic taint_op_t op_item(input logic [2:0] op, input logic [4:0] dst,
                                        input logic [4:0] src, input logic [4:0] src2,
                                        input logic [7:0] dmask, input logic [7:0] smask,
                                        input logic [63:0] ip, input logic mem,
                                        input logic zero);
    taint_op_t it;
    it.op = op;
    it.dst = dst;
    it.src = src;
    it.src2 = src2;
    it.dmask = dmask;
    it.smask = smask;
    it.ip = ip;
    it.mem = mem;
    it.zero = zero;
    return it;
  endfunction

  function automatic void add_row(input taint_op_t it, input bit typed, input logic t,
                                  input logic [63:0] ip, input logic ign);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.res.tainted = t;
    row.res.last_ip = ip;
    row.res.ignored = ign;
    dir_rows.push_back(row);
  endfunction

  // gap before the next transaction, in runs of busy and idle modes
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (rx_hold) return 0;
    if (tx_mode_left == 0) begin
      tx_mode = $urandom_range(2);
      tx_mode_left = $urandom_range(20, 120);
    end else begin
      tx_mode_left--;
    end
    if (tx_mode == 0) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(15, 30);
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(3) == 0) return 5'($urandom_range(3));
    return 5'($urandom_range(NREG - 1));
  endfunction

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01 << $urandom_range(7);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic taint_op_t random_op();
    taint_op_t   it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.ip = {$urandom, $urandom};
    it.mem = 1'($urandom_range(1));
    it.zero = 1'($urandom_range(1));
    it.dmask = pick_mask();
    it.smask = pick_mask();
    it.dst = pick_reg();
    it.src = pick_reg();
    it.src2 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : pick_reg();
    if (pick < 14) it.op = OP_SET;
    else if (pick < 24) it.op = OP_CLEAR;
    else if (pick < 46) it.op = OP_QUERY;
    else if (pick < 62) it.op = OP_MOVE;
    else if (pick < 82) it.op = OP_ARITH;
    else if (pick < 94) it.op = OP_LOAD;
    else if (pick < 97) begin
      // broken index on a defined operation
      it.op = 3'($urandom_range(OP_LOAD));
      if ($urandom_range(1) == 0) it.dst = 5'($urandom_range(NREG, 31));
      else it.src = 5'($urandom_range(NREG, 31));
    end else begin
      it.op = ($urandom_range(1) == 0) ? OP_UNDEF_A : OP_UNDEF_B;
      it.dst = 5'($urandom_range(31));
    end
    if (it.op == OP_ARITH && $urandom_range(5) == 0) begin
      it.src = it.dst;
      it.src2 = it.dst;
      it.zero = 1'b1;
    end
    return it;
  endfunction

  // drive one transaction, wait for acceptance, record its result
  task automatic issue_op(input taint_op_t it, input bit typed, input rbtt_res_t typed_res);
    rbtt_res_t   pred;
    int unsigned gap;
    in_valid_i <= 1'b1;
    operation_i <= it.op;
    dst_reg_i <= it.dst;
    src_reg_i <= it.src;
    second_src_reg_i <= it.src2;
    dst_mask_i <= it.dmask;
    src_mask_i <= it.smask;
    source_ip_i <= it.ip;
    mem_tainted_i <= it.mem;
    zeroing_op_i <= it.zero;
    do @(posedge clk_i); while (in_stall_o);
    pred = track_taint(it);
    pending_results.push_back(typed ? typed_res : pred);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // reset, stimulus and end of run
  initial begin : stim
    taint_op_t   it;
    for (int i = 0; i < NREG; i++) begin
      shadow_lanes[i] = '0;
      shadow_origin[i] = '0;
    end

    // reset state, extremes and ignored transactions
    add_row(op_item(OP_QUERY, 0, 0, 0, 8'hFF, 8'h00, 64'd0, 0, 0), 1, 0, 64'd0, 0);
    add_row(op_item(OP_SET, 0, 31, 31, 8'h01, 8'hFF, '1, 1, 1), 1, 0, 64'd0, 0);
    add_row(op_item(OP_QUERY, 0, 0, 0, 8'h01, 8'h00, 64'd0, 0, 0), 1, 1, '1, 0);
    add_row(op_item(OP_QUERY, 0, 0, 0, 8'hFE, 8'h00, 64'd0, 0, 0), 1, 0, '1, 0);
    add_row(op_item(OP_SET, 15, 0, 0, 8'hFF, 8'h00, 64'h0123_4567_89AB_CDEF, 0, 0),
            1, 0, 64'd0, 0);
    add_row(op_item(OP_QUERY, 15, 0, 0, 8'h80, 8'h00, 64'd0, 0, 0),
            1, 1, 64'h0123_4567_89AB_CDEF, 0);
    add_row(op_item(OP_SET, 16, 0, 0, 8'hFF, 8'h00, '1, 0, 0), 1, 0, 64'd0, 1);
    add_row(op_item(OP_SET, 31, 0, 0, 8'hFF, 8'h00, '1, 1, 1), 1, 0, 64'd0, 1);
    add_row(op_item(OP_MOVE, 1, 16, 0, 8'hFF, 8'hFF, 64'd0, 0, 0), 1, 0, 64'd0, 1);
    add_row(op_item(OP_ARITH, 2, 31, 0, 8'hFF, 8'hFF, 64'd0, 0, 0), 1, 0, 64'd0, 1);
    add_row(op_item(OP_QUERY, 31, 0, 0, 8'hFF, 8'h00, 64'd0, 0, 0), 1, 0, 64'd0, 1);
    add_row(op_item(OP_CLEAR, 20, 0, 0, 8'hFF, 8'h00, 64'd0, 0, 0), 1, 0, 64'd0, 1);
    add_row(op_item(OP_LOAD, 17, 0, 0, 8'hFF, 8'h00, 64'd0, 1, 0), 1, 0, 64'd0, 1);
    add_row(op_item(OP_UNDEF_A, 31, 31, 31, 8'hFF, 8'hFF, '1, 1, 1), 1, 0, 64'd0, 0);
    add_row(op_item(OP_UNDEF_B, 0, 0, 0, 8'hFF, 8'hFF, '1, 1, 1), 1, 0, 64'd0, 0);
    // data movement, checked against the shadow
    add_row(op_item(OP_MOVE, 1, 15, 0, 8'h3C, 8'h0F, 64'd0, 0, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_QUERY, 1, 0, 0, 8'hFF, 8'h00, 64'd0, 0, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_ARITH, 3, 0, 15, 8'h00, 8'h00, 64'd0, 0, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_ARITH, 4, 15, 20, 8'h00, 8'h00, 64'd0, 0, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_ARITH, 15, 15, 15, 8'h00, 8'h00, 64'd0, 0, 1), 0, 0, 64'd0, 0);
    add_row(op_item(OP_QUERY, 15, 0, 0, 8'hFF, 8'h00, 64'd0, 0, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_ARITH, 5, 5, 3, 8'h00, 8'h00, 64'd0, 0, 1), 0, 0, 64'd0, 0);
    add_row(op_item(OP_LOAD, 6, 0, 0, 8'hAA, 8'h00, 64'd0, 1, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_LOAD, 6, 0, 0, 8'h0A, 8'h00, 64'd0, 0, 0), 0, 0, 64'd0, 0);
    add_row(op_item(OP_CLEAR, 0, 0, 0, 8'hFF, 8'h00, 64'd0, 0, 0), 0, 0, 64'd0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue_op(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // random traffic
    repeat (RAND_ITEMS) begin
      it = random_op();
      issue_op(it, 0, '0);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("** register_byte_taint_tracker_core: PASSED **");
    else
      $display("** register_byte_taint_tracker_core: FAILED **");
    $finish;
  end

  // result side: check each transaction, then pick the next stall
  initial begin : rx
    rbtt_res_t   exp;
    int unsigned rx_count;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned burst;
    int unsigned r;
    logic        stall;
    rx_count = 0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: tainted=%0b last_taint_ip=%h ignored=%0b",
                 tainted_o, last_taint_ip_o, ignored_o);
          mismatches++;
        end else begin
          exp = pending_results.pop_front();
          if (tainted_o !== exp.tainted) begin
            $error("tainted: expected %0b, got %0b", exp.tainted, tainted_o);
            mismatches++;
          end
          if (last_taint_ip_o !== exp.last_ip) begin
            $error("last_taint_ip: expected %h, got %h", exp.last_ip, last_taint_ip_o);
            mismatches++;
          end
          if (ignored_o !== exp.ignored) begin
            $error("ignored: expected %0b, got %0b", exp.ignored, ignored_o);
            mismatches++;
          end
        end
        rx_count++;
        // long hold-offs so the pipeline backs up into the input
        if (rx_count == 100 || rx_count == 800) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(2);
          mode_left = $urandom_range(30, 150);
        end else begin
          mode_left--;
        end
        if (burst != 0) begin
          burst--;
          stall = 1'b1;
        end else if (mode == 1) begin
          stall = ($urandom_range(7) == 0);
        end else if (mode == 2) begin
          r = $urandom_range(63);
          if (r == 0) burst = $urandom_range(15, 40);
          else if (r < 16) burst = $urandom_range(3);
          stall = (r < 16);
        end else begin
          stall = 1'b0;
        end
      end
      rx_hold = (hold_left != 0);
      out_stall_i <= stall;
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
        idle = 0;
      else
        idle++;
    end
    $display("** register_byte_taint_tracker_core: FAILED **");
    $finish;
  end

endmodule
